>>> rtl/core/mte_pkg.sv
// shared types and constants for the markov transition estimator
package mte_pkg;

  localparam int VOCAB_MAX_DEF      = 256;
  localparam int COUNT_BITS_DEF     = 16;
  localparam int PROB_FRAC_BITS_DEF = 16;

  localparam int OPCODE_W    = 2;
  localparam int TOKEN_W     = 8;
  localparam int VOCAB_W     = 9;
  localparam int PROB_W      = 17;
  localparam int COUNT_OUT_W = 16;
  localparam int TOTAL_W     = 24;
  localparam int STATUS_W    = 2;

  localparam logic [VOCAB_W-1:0] VOCAB_RESET = 9'd256;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_LK,
    ST_ADD_UPD,
    ST_RD_LK,
    ST_RD_START,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/core/mte_ram.sv
// generic simple dual-port ram with registered read
module mte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/mte_divider.sv
// radix-2 serial divider, one quotient bit per cycle, for num <= den
module mte_divider #(
  parameter int NUM_W  = 16,
  parameter int DEN_W  = 24,
  parameter int FRAC_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [FRAC_W:0]   quot
);

  localparam int SW = $clog2(FRAC_W + 1);
  localparam logic [FRAC_W:0] Q_ONE = {1'b1, {FRAC_W{1'b0}}};

  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [FRAC_W:0]  quot_r, quot_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = (step_r == '0) ? rem_r : {rem_r[DEN_W-1:0], 1'b0};
    ge       = trial >= {1'b0, den_r};
    if (start) begin
      rem_nxt  = (DEN_W + 1)'(num);
      den_nxt  = den;
      quot_nxt = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? (trial - {1'b0, den_r}) : trial;
      quot_nxt = {quot_r[FRAC_W-1:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(FRAC_W)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n) start |-> den != '0)
    else $error("divider started with zero divisor");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < {1'b0, den_r})
    else $error("divider remainder not below divisor");
  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> quot_r <= Q_ONE)
    else $error("divider quotient above one");

endmodule

>>> rtl/core/markov_transition_estimator.sv
// markov transition estimator top level: control, count tables and serial divider
//
// Counts token pairs of a first-order chain in a pair-count ram and a row-total ram
// and reads back count, row total and count/total with PROB_FRAC_BITS fraction bits.
// After reset, and for every clear item, a sweep zeroes the tables one pair entry per
// cycle over 2^(2*clog2(VOCAB_MAX)) entries (65536 at the default), during which no
// item is taken; configuration writes are taken at any time. An add item that forms a
// pair goes through accept, ram lookup, read-modify-write and result. A read item goes
// through accept, ram lookup, divider start, division and result; no new item is taken
// until its result is in the output register. The bit-serial divider retires one
// quotient bit per cycle. A finished result sits in the output register, so the next
// item can be accepted while it waits for its transfer.
module markov_transition_estimator
  import mte_pkg::*;
#(
  parameter int VOCAB_MAX      = VOCAB_MAX_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF,
  parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [VOCAB_W-1:0]     cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [TOKEN_W-1:0]     in_token,
  input  logic [TOKEN_W-1:0]     in_read_row,
  input  logic [TOKEN_W-1:0]     in_read_col,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PROB_W-1:0]      out_probability,
  output logic [COUNT_OUT_W-1:0] out_pair_count,
  output logic [TOTAL_W-1:0]     out_row_total,
  output logic [STATUS_W-1:0]    out_status
);

  localparam int IDX_W   = $clog2(VOCAB_MAX);
  localparam int PAIR_AW = 2 * IDX_W;
  localparam int ROW_W   = COUNT_BITS + IDX_W;
  localparam int NV_W    = $clog2(VOCAB_MAX + 1);
  localparam int CMP_W   = (NV_W > TOKEN_W) ? NV_W : TOKEN_W;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  state_t                   state_r, state_nxt;
  logic [PAIR_AW-1:0]       clr_r, clr_nxt;
  logic                     clr_emit_r, clr_emit_nxt;
  opcode_t                  op_r, op_nxt;
  logic [IDX_W-1:0]         tok_r, tok_nxt;
  logic [IDX_W-1:0]         row_r, row_nxt;
  logic [IDX_W-1:0]         col_r, col_nxt;
  logic [IDX_W-1:0]         prev_r, prev_nxt;
  logic                     have_prev_r, have_prev_nxt;
  logic [VOCAB_W-1:0]       vocab_r;
  logic [PROB_W-1:0]        res_prob_r, res_prob_nxt;
  logic [COUNT_OUT_W-1:0]   res_count_r, res_count_nxt;
  logic [TOTAL_W-1:0]       res_total_r, res_total_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [PROB_W-1:0]        out_prob_r, out_prob_nxt;
  logic [COUNT_OUT_W-1:0]   out_count_r, out_count_nxt;
  logic [TOTAL_W-1:0]       out_total_r, out_total_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;

  logic [NV_W-1:0]          nv;
  logic                     pair_we, row_we;
  logic [PAIR_AW-1:0]       pair_waddr, pair_raddr;
  logic [COUNT_BITS-1:0]    pair_wdata, pair_rdata;
  logic [IDX_W-1:0]         row_waddr, row_raddr;
  logic [ROW_W-1:0]         row_wdata, row_rdata;
  logic                     div_start, div_done;
  logic [COUNT_BITS-1:0]    div_num;
  logic [ROW_W-1:0]         div_den;
  logic [PROB_FRAC_BITS:0]  div_quot;
  logic                     in_xfer, out_free;

  always_comb begin
    if (vocab_r == '0) begin
      nv = NV_W'(1);
    end else if (int'(vocab_r) > VOCAB_MAX) begin
      nv = NV_W'(VOCAB_MAX);
    end else begin
      nv = NV_W'(vocab_r);
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign pair_raddr = (op_r == OP_ADD) ? {prev_r, tok_r} : {row_r, col_r};
  assign row_raddr  = (op_r == OP_ADD) ? prev_r : row_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    clr_emit_nxt   = clr_emit_r;
    op_nxt         = op_r;
    tok_nxt        = tok_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    res_prob_nxt   = res_prob_r;
    res_count_nxt  = res_count_r;
    res_total_nxt  = res_total_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_prob_nxt   = out_prob_r;
    out_count_nxt  = out_count_r;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;
    pair_we        = 1'b0;
    pair_waddr     = clr_r;
    pair_wdata     = '0;
    row_we         = 1'b0;
    row_waddr      = clr_r[IDX_W-1:0];
    row_wdata      = '0;
    div_start      = 1'b0;
    div_num        = pair_rdata;
    div_den        = row_rdata;
    case (state_r)
      ST_CLEAR: begin
        pair_we = 1'b1;
        row_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt    = clr_emit_r ? ST_EMIT : ST_IDLE;
          clr_emit_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt         = opcode_t'(in_opcode);
          tok_nxt        = IDX_W'(in_token);
          row_nxt        = IDX_W'(in_read_row);
          col_nxt        = IDX_W'(in_read_col);
          res_prob_nxt   = '0;
          res_count_nxt  = '0;
          res_total_nxt  = '0;
          res_status_nxt = STATUS_OK;
          state_nxt      = ST_EMIT;
          case (opcode_t'(in_opcode))
            OP_CLEAR: begin
              clr_nxt       = '0;
              clr_emit_nxt  = 1'b1;
              prev_nxt      = '0;
              have_prev_nxt = 1'b0;
              state_nxt     = ST_CLEAR;
            end
            OP_ADD: begin
              if (CMP_W'(in_token) >= CMP_W'(nv)) begin
                res_status_nxt = STATUS_RANGE;
              end else if (!have_prev_r) begin
                prev_nxt      = IDX_W'(in_token);
                have_prev_nxt = 1'b1;
              end else begin
                state_nxt = ST_ADD_LK;
              end
            end
            OP_READ: begin
              if (CMP_W'(in_read_row) >= CMP_W'(nv) ||
                  CMP_W'(in_read_col) >= CMP_W'(nv)) begin
                res_status_nxt = STATUS_RANGE;
              end else begin
                state_nxt = ST_RD_LK;
              end
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_ADD_LK: begin
        state_nxt = ST_ADD_UPD;
      end
      ST_ADD_UPD: begin
        pair_waddr = {prev_r, tok_r};
        row_waddr  = prev_r;
        if (pair_rdata == CMAX) begin
          res_status_nxt = STATUS_SAT;
          res_count_nxt  = COUNT_OUT_W'(pair_rdata);
          res_total_nxt  = TOTAL_W'(row_rdata);
        end else begin
          pair_we        = 1'b1;
          row_we         = 1'b1;
          pair_wdata     = pair_rdata + 1'b1;
          row_wdata      = row_rdata + 1'b1;
          res_count_nxt  = COUNT_OUT_W'(pair_wdata);
          res_total_nxt  = TOTAL_W'(row_wdata);
        end
        prev_nxt  = tok_r;
        state_nxt = ST_EMIT;
      end
      ST_RD_LK: begin
        state_nxt = ST_RD_START;
      end
      ST_RD_START: begin
        div_start     = 1'b1;
        res_count_nxt = COUNT_OUT_W'(pair_rdata);
        res_total_nxt = TOTAL_W'(row_rdata);
        if (row_rdata == '0) begin
          div_num = COUNT_BITS'(1);
          div_den = ROW_W'(nv);
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_prob_nxt = PROB_W'(div_quot);
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_prob_nxt   = res_prob_r;
          out_count_nxt  = res_count_r;
          out_total_nxt  = res_total_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      clr_emit_r  <= 1'b0;
      op_r        <= OP_CLEAR;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      vocab_r     <= VOCAB_RESET;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      op_r        <= op_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        vocab_r <= cfg_wr_data;
      end
    end
    tok_r        <= tok_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    res_prob_r   <= res_prob_nxt;
    res_count_r  <= res_count_nxt;
    res_total_r  <= res_total_nxt;
    res_status_r <= res_status_nxt;
    out_prob_r   <= out_prob_nxt;
    out_count_r  <= out_count_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

  mte_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (1 << PAIR_AW)
  ) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  mte_ram #(
    .WIDTH (ROW_W),
    .DEPTH (1 << IDX_W)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  mte_divider #(
    .NUM_W  (COUNT_BITS),
    .DEN_W  (ROW_W),
    .FRAC_W (PROB_FRAC_BITS)
  ) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid       = out_valid_r;
  assign out_probability = out_prob_r;
  assign out_pair_count  = out_count_r;
  assign out_row_total   = out_total_r;
  assign out_status      = out_status_r;

endmodule
